[hdl/mfs_pkg.sv]
`default_nettype none

package mfs_pkg;

    localparam int TASK_W  = 4;
    localparam int SVC_W   = 6;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 2;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [1:0] {
        STAT_ADMIT  = 2'd0,
        STAT_RAN    = 2'd1,
        STAT_IDLE   = 2'd2,
        STAT_REJECT = 2'd3
    } status_t;

endpackage

`default_nettype wire

[hdl/multilevel_feedback_scheduler.sv]
// Channel  | Direction | Signals                                   | Handshake
// command  | in        | op, task_id, service_time                 | start while busy is low
// result   | out       | status, ran_task, ran_level, finished,    | done, one cycle per beat
//          |           | finish_time, turnaround_time              |
//
// One beat is taken in every cycle; busy never rises.
// Each command is first captured in the input register,
// then the queue, task table and clock updates and the result register load together.
// Reset empties all queues, clears each task's remaining service and active flag, and clears the time;
// no clearing pass is needed. The receiver cannot stall, so each result is shown for exactly one cycle.

`default_nettype none

module multilevel_feedback_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int LEVELS    = 3
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           op,
    input  wire logic [mfs_pkg::TASK_W-1:0]     task_id,
    input  wire logic [mfs_pkg::SVC_W-1:0]      service_time,
    output logic                                done,
    output mfs_pkg::status_t                    status,
    output logic [mfs_pkg::TASK_W-1:0]          ran_task,
    output logic [mfs_pkg::LEVEL_W-1:0]         ran_level,
    output logic                                finished,
    output logic [mfs_pkg::TIME_W-1:0]          finish_time,
    output logic [mfs_pkg::TIME_W-1:0]          turnaround_time
);

    import mfs_pkg::*;

    localparam int ID_W  = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int POS_W = CNT_W + 1;
    localparam int LVL_W = $clog2(LEVELS);

    logic                in_valid_reg;
    logic                in_op_reg;
    logic [TASK_W-1:0]   in_id_reg;
    logic [SVC_W-1:0]    in_svc_reg;

    logic [TASK_W-1:0]   slot_reg [LEVELS][MAX_TASKS];
    logic [ID_W-1:0]     head_reg [LEVELS];
    logic [ID_W-1:0]     head_next [LEVELS];
    logic [CNT_W-1:0]    count_reg [LEVELS];
    logic [CNT_W-1:0]    count_next [LEVELS];
    logic [SVC_W-1:0]    remain_reg [MAX_TASKS];
    logic [TIME_W-1:0]   arrival_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] active_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   now_next;

    logic                done_reg;
    status_t             status_reg;
    status_t             status_next;
    logic [TASK_W-1:0]   ran_task_reg;
    logic [TASK_W-1:0]   ran_task_next;
    logic [LEVEL_W-1:0]  ran_level_reg;
    logic [LEVEL_W-1:0]  ran_level_next;
    logic                finished_reg;
    logic                finished_next;
    logic [TIME_W-1:0]   finish_time_reg;
    logic [TIME_W-1:0]   finish_time_next;
    logic [TIME_W-1:0]   turnaround_reg;
    logic [TIME_W-1:0]   turnaround_next;

    logic [TASK_W-1:0]   head_id_reg [LEVELS];
    logic [TASK_W-1:0]   head_id_next [LEVELS];
    logic [TASK_W-1:0]   second_id_reg [LEVELS];
    logic [TASK_W-1:0]   second_id_next [LEVELS];
    logic [POS_W-1:0]    fetch_sum;
    logic [ID_W-1:0]     fetch_pos;
    logic                found;
    logic [LVL_W-1:0]    sel_lvl;
    logic [TASK_W-1:0]   tick_id;
    logic [ID_W-1:0]     idx;
    logic [SVC_W-1:0]    rem;
    logic [SVC_W-1:0]    rem_dec;
    logic                act;
    logic                id_bad;
    logic                reject;

    logic                push_en;
    logic [LVL_W-1:0]    push_lvl;
    logic [TASK_W-1:0]   push_id;
    logic                push_ok;
    logic [POS_W-1:0]    push_sum;
    logic [ID_W-1:0]     push_pos;
    logic                pop_en;
    logic [LVL_W-1:0]    pop_lvl;

    logic                task_wr;
    logic [SVC_W-1:0]    remain_wdata;
    logic                active_wdata;
    logic                arrival_wr;

    assign busy = 1'b0;

    always_comb
    begin
        found   = 1'b0;
        sel_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found   = 1'b1;
                sel_lvl = LVL_W'(l);
            end
        end
    end

    assign tick_id = head_id_reg[sel_lvl];
    assign idx     = (in_op_reg == OP_TICK) ? ID_W'(tick_id) : ID_W'(in_id_reg);
    assign rem     = remain_reg[idx];
    assign act     = active_reg[idx];
    assign rem_dec = (rem != '0) ? rem - SVC_W'(1) : '0;
    assign id_bad  = int'(in_id_reg) >= MAX_TASKS;
    assign reject  = id_bad | (in_svc_reg == '0) | act;

    always_comb
    begin
        now_next         = now_reg;
        push_en          = 1'b0;
        push_lvl         = '0;
        push_id          = in_id_reg;
        pop_en           = 1'b0;
        pop_lvl          = sel_lvl;
        task_wr          = 1'b0;
        remain_wdata     = in_svc_reg;
        active_wdata     = 1'b1;
        arrival_wr       = 1'b0;
        status_next      = STAT_IDLE;
        ran_task_next    = '0;
        ran_level_next   = '0;
        finished_next    = 1'b0;
        finish_time_next = '0;
        turnaround_next  = '0;

        if (in_valid_reg)
        begin
            if (in_op_reg == OP_ADMIT)
            begin
                ran_task_next = in_id_reg;
                if (reject)
                begin
                    status_next = STAT_REJECT;
                end
                else
                begin
                    status_next = STAT_ADMIT;
                    task_wr     = 1'b1;
                    arrival_wr  = 1'b1;
                    push_en     = 1'b1;
                end
            end
            else
            begin
                now_next = now_reg + TIME_W'(1);
                if (found)
                begin
                    status_next    = STAT_RAN;
                    ran_task_next  = tick_id;
                    ran_level_next = LEVEL_W'(sel_lvl);
                    task_wr        = 1'b1;
                    remain_wdata   = rem_dec;
                    if (rem_dec == '0)
                    begin
                        pop_en           = 1'b1;
                        active_wdata     = 1'b0;
                        finished_next    = 1'b1;
                        finish_time_next = now_next;
                        turnaround_next  = now_next - arrival_reg[idx];
                    end
                    else if (int'(sel_lvl) + 1 < LEVELS)
                    begin
                        pop_en   = 1'b1;
                        push_en  = 1'b1;
                        push_lvl = LVL_W'(int'(sel_lvl) + 1);
                        push_id  = tick_id;
                    end
                end
            end
        end
    end

    always_comb
    begin
        push_ok  = int'(count_reg[push_lvl]) < MAX_TASKS;
        push_sum = POS_W'(head_reg[push_lvl]) + POS_W'(count_reg[push_lvl]);
        if (int'(push_sum) >= MAX_TASKS)
        begin
            push_sum = push_sum - POS_W'(MAX_TASKS);
        end
        push_pos = push_sum[ID_W-1:0];
    end

    // The entry two places behind the head becomes the second entry after a pop.
    always_comb
    begin
        fetch_sum = POS_W'(head_reg[pop_lvl]) + POS_W'(2);
        if (int'(fetch_sum) >= MAX_TASKS)
        begin
            fetch_sum = fetch_sum - POS_W'(MAX_TASKS);
        end
        fetch_pos = fetch_sum[ID_W-1:0];
    end

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            head_next[l]      = head_reg[l];
            count_next[l]     = count_reg[l];
            head_id_next[l]   = head_id_reg[l];
            second_id_next[l] = second_id_reg[l];
            if (pop_en && (pop_lvl == LVL_W'(l)) && (count_reg[l] != '0))
            begin
                head_next[l]    = (head_reg[l] == ID_W'(MAX_TASKS - 1)) ? '0
                                  : head_reg[l] + ID_W'(1);
                count_next[l]   = count_next[l] - CNT_W'(1);
                head_id_next[l] = second_id_reg[l];
            end
            if (push_en && push_ok && (push_lvl == LVL_W'(l)))
            begin
                count_next[l] = count_next[l] + CNT_W'(1);
                if (count_reg[l] == '0)
                begin
                    head_id_next[l] = push_id;
                end
                if (count_reg[l] == CNT_W'(1))
                begin
                    second_id_next[l] = push_id;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            now_reg      <= '0;
            active_reg   <= '0;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                remain_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            now_reg      <= now_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            if (task_wr)
            begin
                remain_reg[idx] <= remain_wdata;
                active_reg[idx] <= active_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_op_reg  <= op;
            in_id_reg  <= task_id;
            in_svc_reg <= service_time;
        end
        if (push_en && push_ok)
        begin
            slot_reg[push_lvl][push_pos] <= push_id;
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            head_id_reg[l] <= head_id_next[l];
            if (pop_en && (pop_lvl == LVL_W'(l)))
            begin
                second_id_reg[l] <= slot_reg[l][fetch_pos];
            end
            else
            begin
                second_id_reg[l] <= second_id_next[l];
            end
        end
        if (arrival_wr)
        begin
            arrival_reg[idx] <= now_reg;
        end
        status_reg      <= status_next;
        ran_task_reg    <= ran_task_next;
        ran_level_reg   <= ran_level_next;
        finished_reg    <= finished_next;
        finish_time_reg <= finish_time_next;
        turnaround_reg  <= turnaround_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign ran_task        = ran_task_reg;
    assign ran_level       = ran_level_reg;
    assign finished        = finished_reg;
    assign finish_time     = finish_time_reg;
    assign turnaround_time = turnaround_reg;

    logic [31:0] queued_total;

    always_comb
    begin
        queued_total = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            queued_total = queued_total + 32'(count_reg[l]);
        end
    end

    a_queued_matches_active: assert property (@(posedge clk) disable iff (!rst_n)
        queued_total == 32'($countones(active_reg)))
        else $error("queue occupancy differs from the number of active tasks");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted command produced no result two cycles later");

    a_finish_only_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        done && finished |-> status == STAT_RAN && finish_time == $past(now_reg) + 32'd1)
        else $error("finish reported outside a run or with a wrong time");

    a_idle_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_IDLE |-> !finished && ran_task == '0 && finish_time == '0)
        else $error("idle tick carries task data");

endmodule

`default_nettype wire
